// ===== design/lpkv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpkv_pkg - shared types and constants for the key/value table
// Command and status codes, stream word widths and parameter defaults.
// ----------------------------------------------------------------------------
package lpkv_pkg;

    // parameter defaults
    localparam int TABLE_SLOTS_DEF = 32;
    localparam int KEY_BYTES_DEF   = 8;
    localparam int VALUE_BITS_DEF  = 40;

    // field widths of the stream words
    localparam int CMD_W       = 2;
    localparam int KEY_FIELD_W = 64;
    localparam int VAL_FIELD_W = 40;
    localparam int STATUS_W    = 2;

    // input word: cmd, name_key, value_in -> 106 bits, padded to 14 bytes
    localparam int IN_TDATA_W  = 112;
    // output word: status, value_out -> 42 bits, padded to 6 bytes
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_UPDATE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

endpackage
`default_nettype wire

// ===== design/lpkv_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpkv_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpkv_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/lpkv_hash.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpkv_hash - home slot unit
// Adds the key bytes when a command is taken, then reduces the sum modulo the
// table size with a reciprocal multiply and a multiply-subtract, one step per
// cycle.
// ----------------------------------------------------------------------------
module lpkv_hash #(
    parameter  int TABLE_SLOTS = 32,
    parameter  int KEY_BYTES   = 8,
    localparam int IDX_W       = $clog2(TABLE_SLOTS),
    localparam int KEY_W       = 8 * KEY_BYTES
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [KEY_W-1:0] key,
    output logic                  done,
    output logic      [IDX_W-1:0] home
);

    localparam int SUM_W     = $clog2(KEY_BYTES * 255 + 1);
    // quotient = (sum * RECIP) >> SHIFT is exact for every sum below 2^SUM_W
    localparam int SHIFT     = SUM_W + IDX_W;
    localparam int RECIP_W   = SUM_W + 2;
    localparam int PROD_W    = SUM_W + SHIFT;
    localparam int DIFF_W    = SUM_W + IDX_W + 1;
    localparam int RECIP_VAL = ((1 << SHIFT) + TABLE_SLOTS - 1) / TABLE_SLOTS;
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_VAL);
    localparam logic [DIFF_W-1:0]  MODULUS = DIFF_W'(TABLE_SLOTS);

    typedef enum logic [1:0] {
        H_QUOT,
        H_REM,
        H_DONE
    } hstep_t;

    logic [SUM_W-1:0]  byte_sum;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  quot_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic              busy_reg;
    hstep_t            step_reg;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  quot;
    logic [DIFF_W-1:0] back;
    logic [DIFF_W-1:0] diff;

    // byte sum of the key
    always_comb begin
        byte_sum = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            byte_sum = byte_sum + SUM_W'(key[8*b +: 8]);
        end
    end

    // quotient by reciprocal multiply, remainder by multiply-subtract
    assign prod = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign quot = prod[SHIFT +: SUM_W];
    assign back = DIFF_W'(quot_reg) * MODULUS;
    assign diff = DIFF_W'(sum_reg) - back;

    assign done = busy_reg && (step_reg == H_DONE);
    assign home = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= H_QUOT;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= H_QUOT;
            sum_reg  <= byte_sum;
        end else if (busy_reg) begin
            case (step_reg)
                H_QUOT: begin
                    quot_reg <= quot;
                    step_reg <= H_REM;
                end
                H_REM: begin
                    rem_reg  <= diff[IDX_W-1:0];
                    step_reg <= H_DONE;
                end
                default: begin
                    busy_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/linear_probe_key_value_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_key_value_table - open-addressed key/value table
// Add, delete, find and update on 64-bit name keys with linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream, one word each; every command gives one
//   result word on the m_ stream (status plus value for a find).
//   The home slot is the byte sum of the key modulo TABLE_SLOTS, worked out
//   in steps (byte sum, reciprocal multiply, multiply-subtract). The
//   probe loop then reads one slot per cycle from the slot RAM.
//   A command with a nonzero key probes from 1 to TABLE_SLOTS slots before
//   its result is loaded into the output register. A zero key skips the
//   hash and the probe loop and answers not found.
//   One command is worked on at a time; s_tready is high only when idle, so
//   the next command is taken only once the result of the last is loaded.
//   The result sits in an output register, so the next command is taken
//   while an earlier result still waits for m_tready. A stalled receiver
//   holds the block only once a second result is ready to go out.
//   After reset the table is cleared one slot a cycle, with s_tready low.
// ----------------------------------------------------------------------------
module linear_probe_key_value_table #(
    parameter int TABLE_SLOTS = lpkv_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = lpkv_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS  = lpkv_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: [1:0] cmd, [65:2] name_key, [105:66] value_in, [111:106] zero
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [lpkv_pkg::IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: [1:0] status, [41:2] value_out, [47:42] zero
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [lpkv_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import lpkv_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int KEY_W   = 8 * KEY_BYTES;
    localparam int SLOT_W  = KEY_W + VALUE_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_ISSUE,
        S_CHECK,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    status_t                status_reg, status_next;
    logic [VAL_FIELD_W-1:0] vout_reg, vout_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // input word fields
    cmd_t                   in_cmd;
    logic [KEY_FIELD_W-1:0] in_key_full;
    logic [KEY_W-1:0]       in_key;
    logic [63:0]            in_val_ext;

    // slot RAM port signals
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [SLOT_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [SLOT_W-1:0]      ram_rdata;
    logic [KEY_W-1:0]       rd_key;
    logic [VALUE_BITS-1:0]  rd_val;
    logic [63:0]            rd_val_ext;
    logic                   slot_busy;
    logic                   lap_last;
    logic [IDX_W-1:0]       idx_inc;

    logic                   hash_start;
    logic                   hash_done;
    logic [IDX_W-1:0]       hash_home;

    assign in_cmd      = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_key_full = s_tdata[CMD_W +: KEY_FIELD_W];
    assign in_key      = in_key_full[KEY_W-1:0];
    assign in_val_ext  = 64'(s_tdata[CMD_W + KEY_FIELD_W +: VAL_FIELD_W]);

    assign rd_key     = ram_rdata[KEY_W-1:0];
    assign rd_val     = ram_rdata[KEY_W +: VALUE_BITS];
    assign rd_val_ext = 64'(rd_val);
    assign slot_busy  = (rd_key != '0) && (rd_val != '0);
    assign lap_last   = (cnt_reg == LAST_IDX);
    assign idx_inc    = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    assign s_tready   = (state_reg == S_IDLE);
    assign hash_start = s_tvalid && s_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    lpkv_hash #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .KEY_BYTES  (KEY_BYTES)
    ) u_hash (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (hash_start),
        .key    (in_key),
        .done   (hash_done),
        .home   (hash_home)
    );

    lpkv_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slots (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // sequencer: clear, hash, probe loop, result
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        vout_next     = vout_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = '0;
        ram_raddr     = idx_reg;

        // output word taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_inc;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = in_cmd;
                    key_next  = in_key;
                    val_next  = in_val_ext[VALUE_BITS-1:0];
                    cnt_next  = '0;
                    vout_next = '0;
                    if (in_key == '0) begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    idx_next   = hash_home;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                // read of the following slot is issued speculatively
                ram_raddr = idx_inc;
                if (cmd_reg == CMD_ADD) begin
                    if (!slot_busy) begin
                        ram_we      = 1'b1;
                        ram_wdata   = {val_reg, key_reg};
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end else if (lap_last) begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        idx_next = idx_inc;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else if (rd_key == key_reg) begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (cmd_reg)
                        CMD_DELETE: begin
                            ram_we    = 1'b1;
                            ram_wdata = '0;
                        end
                        CMD_UPDATE: begin
                            ram_we    = 1'b1;
                            ram_wdata = {val_reg, key_reg};
                        end
                        CMD_FIND: begin
                            vout_next = rd_val_ext[VAL_FIELD_W-1:0];
                        end
                        default: begin
                            vout_next = '0;
                        end
                    endcase
                end else if (!slot_busy || lap_last) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end else begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE: begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({vout_reg, status_reg});
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        vout_reg    <= vout_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
`default_nettype wire

// ===== design/lpkv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpkv_checker - port-level checks for the key/value table
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
module lpkv_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [lpkv_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    import lpkv_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed under stall");

    // one command at a time: busy right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while busy");

    // table clear runs right after reset, no commands taken
    a_clear_after_reset: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !s_tready)
        else $error("command accepted during table clear");

    // value only comes back with an ok status
    a_value_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> m_tdata[41:2] == '0)
        else $error("value returned with failing status");

    // status code is always a defined one
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ST_OK) || (m_tdata[1:0] == ST_NOT_FOUND) ||
                     (m_tdata[1:0] == ST_FULL))
        else $error("undefined status code");

endmodule

bind linear_probe_key_value_table lpkv_checker u_lpkv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
`default_nettype wire
